FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Checked outside of reset only.
`define CO2_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define CO2_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

FILE: hw/rtl/co2msq_pkg.sv
`timescale 1ns / 1ps
// Types, codes and helper functions of the CO2 measurement sequencer.
package co2msq_pkg;

  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 64;

  localparam logic [1:0] REQ_START  = 2'd0;
  localparam logic [1:0] REQ_WAKE   = 2'd1;
  localparam logic [1:0] REQ_STATUS = 2'd2;

  localparam logic [2:0] CMD_POWER_OFF   = 3'd0;
  localparam logic [2:0] CMD_POWER_ON    = 3'd1;
  localparam logic [2:0] CMD_READ_MODE   = 3'd2;
  localparam logic [2:0] CMD_WRITE_TRIG  = 3'd3;
  localparam logic [2:0] CMD_READ_VALUE  = 3'd4;
  localparam logic [2:0] CMD_READ_STATUS = 3'd5;

  localparam logic [3:0] CODE_OK         = 4'd0;
  localparam logic [3:0] CODE_NOT_READY  = 4'd8;
  localparam logic [3:0] CODE_GENERAL    = 4'd12;
  localparam logic [3:0] CODE_WRONG_MODE = 4'd13;
  localparam logic [3:0] CODE_BUS        = 4'd14;

  localparam logic [8:0] DELAY_NONE  = 9'd0;
  localparam logic [8:0] DELAY_END   = 9'd1;
  localparam logic [8:0] DELAY_SHORT = 9'd10;
  localparam logic [8:0] DELAY_POWER = 9'd100;
  localparam logic [8:0] DELAY_VALUE = 9'd300;

  localparam logic [7:0]  TRIGGER_BYTE = 8'h01;
  localparam logic [15:0] CO2_UNKNOWN  = 16'h7FFF;
  localparam logic [16:0] RETRY_MAX    = 17'h1FFFF;

  localparam logic       ADDR_SINGLE_MODE  = 1'b0;
  localparam logic       ADDR_SAMPLE_LIMIT = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_MODE    = 3'd1,
    PH_TRIGGER = 3'd2,
    PH_VALUE   = 3'd3,
    PH_STATUS  = 3'd4,
    PH_COLLECT = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    CS_WAIT,
    CS_EXEC,
    CS_PAYLOAD
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic emit_pay;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic more;
    logic pay_last;
  } dp_stat_t;

  typedef struct packed {
    logic               update;
    logic [3:0]         code;
    logic               known;
    logic [15:0]        temp;
    logic signed [15:0] co2;
    logic               last;
    logic [7:0]         payload;
    logic [8:0]         delay;
    logic [2:0]         command;
  } result_t;

  // Lowest set flag among bits 0 to 10 wins; other flags give the general code.
  function automatic logic [3:0] decode_error(input logic [15:0] w);
    logic [3:0] code;
    code = (w == 16'd0) ? CODE_OK : CODE_GENERAL;
    for (int b = 10; b >= 0; b--) begin
      if (w[b]) begin
        code = 4'(b + 1);
      end
    end
    return code;
  endfunction

endpackage

FILE: hw/rtl/co2msq_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine that sequences item intake and result emission.
module co2msq_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  co2msq_pkg::dp_stat_t  stat,
  output co2msq_pkg::ctrl_cmd_t cmd
);

  co2msq_pkg::ctrl_state_t state_r;
  co2msq_pkg::ctrl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= co2msq_pkg::CS_WAIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      co2msq_pkg::CS_WAIT: begin
        if (in_valid) begin
          state_nxt = co2msq_pkg::CS_EXEC;
        end
      end
      co2msq_pkg::CS_EXEC: begin
        if (stat.out_free) begin
          state_nxt = stat.more ? co2msq_pkg::CS_PAYLOAD : co2msq_pkg::CS_WAIT;
        end
      end
      co2msq_pkg::CS_PAYLOAD: begin
        if (stat.out_free && stat.pay_last) begin
          state_nxt = co2msq_pkg::CS_WAIT;
        end
      end
      default: state_nxt = co2msq_pkg::CS_WAIT;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd.load     = 1'b0;
    cmd.exec     = 1'b0;
    cmd.emit_pay = 1'b0;
    unique case (state_r)
      co2msq_pkg::CS_WAIT: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      co2msq_pkg::CS_EXEC: begin
        cmd.exec = stat.out_free;
      end
      co2msq_pkg::CS_PAYLOAD: begin
        cmd.emit_pay = stat.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

FILE: hw/rtl/co2msq_dp.sv
`timescale 1ns / 1ps
// Datapath: item register, phase and retry state, status store and result register.
module co2msq_dp #(
  parameter int STATUS_BYTES = 24
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 single_mode,
  input  logic [15:0]                          sample_limit,
  input  logic [1:0]                           in_user,
  input  logic [co2msq_pkg::IN_DATA_W-1:0]     in_data,
  input  logic                                 in_last,
  input  logic                                 out_ready,
  input  co2msq_pkg::ctrl_cmd_t                cmd,
  output co2msq_pkg::dp_stat_t                 stat,
  output logic                                 out_valid,
  output co2msq_pkg::result_t                  out_res
);

  localparam int IW = (STATUS_BYTES > 1) ? $clog2(STATUS_BYTES) : 1;
  localparam int CW = $clog2(STATUS_BYTES + 1);
  localparam logic [CW-1:0] COUNT_FULL = CW'(STATUS_BYTES);
  localparam logic [IW-1:0] IDX_LAST   = IW'(STATUS_BYTES - 1);

  logic [1:0]  req_r;
  logic        ok_r;
  logic [7:0]  mode_r;
  logic [15:0] err_r;
  logic [15:0] co2w_r;
  logic [15:0] tempw_r;
  logic [7:0]  sbyte_r;
  logic        send_r;

  co2msq_pkg::phase_t phase_r;
  co2msq_pkg::phase_t phase_nxt;
  logic [16:0]        retry_r;
  logic [16:0]        retry_nxt;
  logic [CW-1:0]      sidx_r;
  logic [CW-1:0]      sidx_nxt;
  logic [IW-1:0]      pidx_r;
  logic [7:0]         store_r [STATUS_BYTES];
  logic               nonzero_r;
  logic [15:0]        co2_r;
  logic [15:0]        co2_nxt;
  logic [15:0]        temp_r;
  logic [15:0]        temp_nxt;
  logic               known_r;
  logic               known_nxt;
  logic               out_valid_r;
  co2msq_pkg::result_t res_r;
  co2msq_pkg::result_t res_nxt;

  logic       clear_store;
  logic       wr_en;
  logic       set_unk;
  logic       take_read;
  logic       emit;
  logic [2:0] e_cmd;
  logic [8:0] e_delay;
  logic [7:0] e_pay;
  logic       e_last;
  logic       e_upd;
  logic [3:0] e_code;
  logic [3:0] err_code;
  logic       timed_out;
  logic       mode_bad;

  assign err_code  = co2msq_pkg::decode_error(err_r);
  assign timed_out = retry_r > {1'b0, sample_limit};
  assign mode_bad  = mode_r != {7'd0, single_mode};

  assign stat.out_free = !out_valid_r || out_ready;
  assign stat.more     = (req_r == co2msq_pkg::REQ_WAKE) &&
                         (phase_r == co2msq_pkg::PH_TRIGGER) && nonzero_r;
  assign stat.pay_last = pidx_r == IDX_LAST;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r   <= in_user;
      ok_r    <= in_data[0];
      mode_r  <= in_data[8:1];
      err_r   <= in_data[24:9];
      co2w_r  <= in_data[40:25];
      tempw_r <= in_data[56:41];
      sbyte_r <= in_data[64:57];
      send_r  <= in_last;
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    retry_nxt   = retry_r;
    sidx_nxt    = sidx_r;
    clear_store = 1'b0;
    wr_en       = 1'b0;
    set_unk     = 1'b0;
    take_read   = 1'b0;
    emit        = 1'b0;
    e_cmd       = co2msq_pkg::CMD_POWER_OFF;
    e_delay     = co2msq_pkg::DELAY_NONE;
    e_pay       = 8'd0;
    e_last      = 1'b1;
    e_upd       = 1'b0;
    e_code      = co2msq_pkg::CODE_OK;
    if (cmd.exec) begin
      case (req_r)
        co2msq_pkg::REQ_START: begin
          phase_nxt = co2msq_pkg::PH_MODE;
          retry_nxt = 17'd0;
          emit      = 1'b1;
          e_cmd     = co2msq_pkg::CMD_POWER_ON;
          e_delay   = co2msq_pkg::DELAY_POWER;
        end
        co2msq_pkg::REQ_STATUS: begin
          if (phase_r == co2msq_pkg::PH_COLLECT) begin
            if (sidx_r < COUNT_FULL) begin
              wr_en    = 1'b1;
              sidx_nxt = sidx_r + 1'b1;
            end
            if (send_r) begin
              phase_nxt = co2msq_pkg::PH_IDLE;
              emit      = 1'b1;
            end
          end
        end
        co2msq_pkg::REQ_WAKE: begin
          case (phase_r)
            co2msq_pkg::PH_IDLE: begin
              emit = 1'b1;
            end
            co2msq_pkg::PH_MODE: begin
              emit  = 1'b1;
              e_cmd = co2msq_pkg::CMD_READ_MODE;
              if (!ok_r || mode_bad) begin
                set_unk   = 1'b1;
                phase_nxt = co2msq_pkg::PH_IDLE;
                e_delay   = co2msq_pkg::DELAY_END;
                e_upd     = 1'b1;
                e_code    = ok_r ? co2msq_pkg::CODE_WRONG_MODE : co2msq_pkg::CODE_BUS;
              end else if (single_mode) begin
                phase_nxt = co2msq_pkg::PH_TRIGGER;
                e_delay   = co2msq_pkg::DELAY_SHORT;
              end else begin
                phase_nxt = co2msq_pkg::PH_VALUE;
                e_delay   = co2msq_pkg::DELAY_VALUE;
              end
            end
            co2msq_pkg::PH_TRIGGER: begin
              emit      = 1'b1;
              set_unk   = !ok_r;
              phase_nxt = ok_r ? co2msq_pkg::PH_VALUE : co2msq_pkg::PH_IDLE;
              e_cmd     = co2msq_pkg::CMD_WRITE_TRIG;
              e_delay   = ok_r ? co2msq_pkg::DELAY_VALUE : co2msq_pkg::DELAY_END;
              e_pay     = co2msq_pkg::TRIGGER_BYTE;
              e_last    = !nonzero_r;
              e_upd     = !ok_r && !nonzero_r;
              e_code    = co2msq_pkg::CODE_BUS;
            end
            co2msq_pkg::PH_VALUE: begin
              emit  = 1'b1;
              e_cmd = co2msq_pkg::CMD_READ_VALUE;
              if (ok_r && retry_r != co2msq_pkg::RETRY_MAX) begin
                retry_nxt = retry_r + 1'b1;
              end
              if (!ok_r || timed_out ||
                  (err_code != co2msq_pkg::CODE_OK &&
                   err_code != co2msq_pkg::CODE_NOT_READY)) begin
                set_unk   = 1'b1;
                phase_nxt = co2msq_pkg::PH_IDLE;
                e_delay   = co2msq_pkg::DELAY_END;
                e_upd     = 1'b1;
                e_code    = !ok_r ? co2msq_pkg::CODE_BUS :
                            timed_out ? co2msq_pkg::CODE_NOT_READY : err_code;
              end else if (err_code == co2msq_pkg::CODE_NOT_READY) begin
                e_delay = co2msq_pkg::DELAY_VALUE;
              end else begin
                take_read = 1'b1;
                e_upd     = 1'b1;
                if (single_mode) begin
                  phase_nxt = co2msq_pkg::PH_STATUS;
                  e_delay   = co2msq_pkg::DELAY_SHORT;
                end else begin
                  phase_nxt = co2msq_pkg::PH_IDLE;
                  e_delay   = co2msq_pkg::DELAY_END;
                end
              end
            end
            co2msq_pkg::PH_STATUS: begin
              emit        = 1'b1;
              clear_store = 1'b1;
              e_cmd       = co2msq_pkg::CMD_READ_STATUS;
              if (!ok_r) begin
                phase_nxt = co2msq_pkg::PH_IDLE;
                e_delay   = co2msq_pkg::DELAY_END;
                e_upd     = 1'b1;
                e_code    = co2msq_pkg::CODE_BUS;
              end else begin
                sidx_nxt  = '0;
                phase_nxt = co2msq_pkg::PH_COLLECT;
              end
            end
            default: begin
              emit = 1'b0;
            end
          endcase
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end else if (cmd.emit_pay) begin
      emit    = 1'b1;
      e_cmd   = co2msq_pkg::CMD_WRITE_TRIG;
      e_delay = ok_r ? co2msq_pkg::DELAY_VALUE : co2msq_pkg::DELAY_END;
      e_pay   = store_r[pidx_r];
      e_last  = stat.pay_last;
      e_upd   = !ok_r && stat.pay_last;
      e_code  = co2msq_pkg::CODE_BUS;
    end
  end

  always_comb begin
    co2_nxt   = co2_r;
    temp_nxt  = temp_r;
    known_nxt = known_r;
    if (set_unk) begin
      co2_nxt   = co2msq_pkg::CO2_UNKNOWN;
      temp_nxt  = 16'd0;
      known_nxt = 1'b0;
    end else if (take_read) begin
      co2_nxt   = co2w_r;
      temp_nxt  = tempw_r;
      known_nxt = 1'b1;
    end
    res_nxt.command = e_cmd;
    res_nxt.delay   = e_delay;
    res_nxt.payload = e_pay;
    res_nxt.last    = e_last;
    res_nxt.update  = e_upd;
    res_nxt.co2     = e_upd ? $signed(co2_nxt) : 16'sd0;
    res_nxt.temp    = e_upd ? temp_nxt : 16'd0;
    res_nxt.known   = e_upd & known_nxt;
    res_nxt.code    = e_upd ? e_code : co2msq_pkg::CODE_OK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= co2msq_pkg::PH_IDLE;
      retry_r   <= 17'd0;
      sidx_r    <= '0;
      co2_r     <= co2msq_pkg::CO2_UNKNOWN;
      temp_r    <= 16'd0;
      known_r   <= 1'b0;
      nonzero_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      retry_r <= retry_nxt;
      sidx_r  <= sidx_nxt;
      co2_r   <= co2_nxt;
      temp_r  <= temp_nxt;
      known_r <= known_nxt;
      if (clear_store) begin
        nonzero_r <= 1'b0;
      end else if (wr_en && sbyte_r != 8'd0) begin
        nonzero_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear_store) begin
      for (int i = 0; i < STATUS_BYTES; i++) begin
        store_r[i] <= 8'd0;
      end
    end else if (wr_en) begin
      store_r[sidx_r[IW-1:0]] <= sbyte_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      pidx_r <= '0;
    end else if (cmd.emit_pay) begin
      pidx_r <= pidx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

endmodule

FILE: hw/rtl/co2_sensor_measure_sequencer_top.sv
`timescale 1ns / 1ps
// Top level of the CO2 measurement sequencer: ports, registers and wiring.
//
// Requests enter on the in_ stream: in_tuser carries the request kind (start,
// timer wake with the outcome of the pending bus transaction, status byte) and
// in_tlast marks the final byte of a status block. Results leave on the out_
// stream with tlast on the final result of each request. The APB port holds the
// mode select at address 0 and the sample limit at address 4.
// A request is taken in the wait state and decoded in the execute state once the
// output register is free; its first result is then registered there. A trigger
// write with a non-empty saved status emits STATUS_BYTES + 1 results at one per
// cycle while the receiver is ready, all through the single output register.
// A new request is accepted as soon as the previous one has placed its last
// result in the output register, even while that result is still waiting.
// When the receiver stalls, the output register holds its result and the
// sequencer waits. Reset returns to the idle phase, clears the saved status
// store, marks the readings unknown and loads the register defaults.
module co2_sensor_measure_sequencer_top #(
  parameter int STATUS_BYTES = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // bus_ok, mode_byte, error_word, co2_word, temp_word, status_byte, zero fill
  input  logic [co2msq_pkg::IN_DATA_W-1:0]  in_tdata,
  // req_type
  input  logic [1:0]                        in_tuser,
  input  logic                              in_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // command, delay_ms, payload_byte, co2_value, temp_centi, temp_known,
  // status_code, status_update, zero fill
  output logic [co2msq_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                              out_tlast,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  logic        single_mode_r;
  logic        single_mode_nxt;
  logic [15:0] sample_limit_r;
  logic [15:0] sample_limit_nxt;
  logic        cfg_wr;

  co2msq_pkg::ctrl_cmd_t cmd;
  co2msq_pkg::dp_stat_t  stat;
  co2msq_pkg::result_t   res;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    single_mode_nxt  = single_mode_r;
    sample_limit_nxt = sample_limit_r;
    if (cfg_wr) begin
      unique case (paddr[2])
        co2msq_pkg::ADDR_SINGLE_MODE:  single_mode_nxt  = pwdata[0];
        co2msq_pkg::ADDR_SAMPLE_LIMIT: sample_limit_nxt = pwdata[15:0];
        default:                       single_mode_nxt  = single_mode_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      single_mode_r  <= 1'b0;
      sample_limit_r <= 16'd1;
    end else begin
      single_mode_r  <= single_mode_nxt;
      sample_limit_r <= sample_limit_nxt;
    end
  end

  assign prdata = (paddr[2] == co2msq_pkg::ADDR_SAMPLE_LIMIT) ?
                  {16'd0, sample_limit_r} : {31'd0, single_mode_r};

  co2msq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  co2msq_dp #(
    .STATUS_BYTES (STATUS_BYTES)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .single_mode  (single_mode_r),
    .sample_limit (sample_limit_r),
    .in_user      (in_tuser),
    .in_data      (in_tdata),
    .in_last      (in_tlast),
    .out_ready    (out_tready),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (out_tvalid),
    .out_res      (res)
  );

  assign out_tdata = {6'd0, res.update, res.code, res.known, res.temp, res.co2,
                      res.payload, res.delay, res.command};
  assign out_tlast = res.last;

endmodule

FILE: hw/rtl/co2msq_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the CO2 measurement sequencer, bound to the top level.
`include "assert_macros.svh"

module co2msq_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [co2msq_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                              out_tlast
);

  `CO2_ASSERT_ALWAYS(a_reset_empties_out, !rst_n |=> !out_tvalid, "result valid after reset")
  `CO2_ASSERT(a_out_holds, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled result changed")
  `CO2_ASSERT(a_one_request, in_tvalid && in_tready |=> !in_tready, "request taken while one is decoding")
  `CO2_ASSERT(a_update_is_last, out_tvalid && out_tdata[57] |-> out_tlast, "status update on a non-final result")
  `CO2_ASSERT(a_code_needs_update, out_tvalid && !out_tdata[57] |-> out_tdata[56:53] == co2msq_pkg::CODE_OK, "status code without update")

endmodule

bind co2_sensor_measure_sequencer_top co2msq_checker u_co2msq_checker (.*);

FILE: dv/co2msq_checker.sv
`timescale 1ns / 1ps
// Checker for the CO2 measurement sequencer: tracks registers, predicts and compares results.
module co2msq_tb_checker #(
  parameter int STATUS_BYTES = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  input  logic [co2msq_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [1:0]                        in_tuser,
  input  logic                              in_tlast,
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic [co2msq_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                              out_tlast,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  input  logic                              pready,
  output int                                fail_count,
  output int                                pending,
  output int                                checked
);
  import co2msq_pkg::*;

  logic        single_mode;
  logic [15:0] sample_limit;
  phase_t      seq_phase;
  logic [16:0] retries;
  logic [7:0]  saved_bytes [STATUS_BYTES];
  int          status_fill;
  logic [15:0] co2_hold;
  logic [15:0] temp_hold;
  logic        known_hold;
  result_t     awaited_cmds[$];

  function automatic void emit_cmd(logic [2:0] cmd, logic [8:0] dly, logic [7:0] pay,
                                   logic fin, logic upd, logic [3:0] code);
    result_t r;
    r.command = cmd;
    r.delay   = dly;
    r.payload = pay;
    r.last    = fin;
    r.update  = upd;
    r.co2     = upd ? co2_hold : 16'd0;
    r.temp    = upd ? temp_hold : 16'd0;
    r.known   = upd ? known_hold : 1'b0;
    r.code    = upd ? code : CODE_OK;
    awaited_cmds.push_back(r);
  endfunction

  function automatic void mark_unknown();
    co2_hold   = CO2_UNKNOWN;
    temp_hold  = 16'd0;
    known_hold = 1'b0;
  endfunction

  function automatic void abort_measurement(logic [2:0] cmd, logic [3:0] code);
    mark_unknown();
    seq_phase = PH_IDLE;
    emit_cmd(cmd, DELAY_END, 8'd0, 1'b1, 1'b1, code);
  endfunction

  // Lowest set flag among bits 0 to 10 decides the code.
  function automatic logic [3:0] flag_priority(logic [15:0] w);
    int b;
    if (w == 16'd0) begin
      return CODE_OK;
    end
    for (b = 0; b <= 10; b++) begin
      if (w[b]) begin
        return 4'(b + 1);
      end
    end
    return CODE_GENERAL;
  endfunction

  function automatic void advance_sequence(logic [1:0] req, logic ok, logic [7:0] mode,
                                           logic [15:0] errw, logic [15:0] co2w,
                                           logic [15:0] tempw, logic [7:0] sbyte,
                                           logic send);
    logic [3:0] code;
    logic       timed_out;
    logic       any_saved;
    int         n;
    int         k;
    any_saved = 1'b0;
    if (req == REQ_START) begin
      seq_phase = PH_MODE;
      retries   = '0;
      emit_cmd(CMD_POWER_ON, DELAY_POWER, 8'd0, 1'b1, 1'b0, CODE_OK);
    end else if (req == REQ_STATUS) begin
      if (seq_phase == PH_COLLECT) begin
        if (status_fill < STATUS_BYTES) begin
          saved_bytes[status_fill] = sbyte;
          status_fill++;
        end
        if (send) begin
          seq_phase = PH_IDLE;
          emit_cmd(CMD_POWER_OFF, DELAY_NONE, 8'd0, 1'b1, 1'b0, CODE_OK);
        end
      end
    end else if (req == REQ_WAKE) begin
      case (seq_phase)
        PH_IDLE: begin
          emit_cmd(CMD_POWER_OFF, DELAY_NONE, 8'd0, 1'b1, 1'b0, CODE_OK);
        end
        PH_MODE: begin
          if (!ok) begin
            abort_measurement(CMD_READ_MODE, CODE_BUS);
          end else if (mode != {7'd0, single_mode}) begin
            abort_measurement(CMD_READ_MODE, CODE_WRONG_MODE);
          end else if (single_mode) begin
            seq_phase = PH_TRIGGER;
            emit_cmd(CMD_READ_MODE, DELAY_SHORT, 8'd0, 1'b1, 1'b0, CODE_OK);
          end else begin
            seq_phase = PH_VALUE;
            emit_cmd(CMD_READ_MODE, DELAY_VALUE, 8'd0, 1'b1, 1'b0, CODE_OK);
          end
        end
        PH_TRIGGER: begin
          for (k = 0; k < STATUS_BYTES; k++) begin
            if (saved_bytes[k] != 8'd0) begin
              any_saved = 1'b1;
            end
          end
          n = any_saved ? STATUS_BYTES + 1 : 1;
          if (!ok) begin
            mark_unknown();
          end
          for (k = 0; k < n; k++) begin
            emit_cmd(CMD_WRITE_TRIG, ok ? DELAY_VALUE : DELAY_END,
                     (k == 0) ? TRIGGER_BYTE : saved_bytes[(k == 0) ? 0 : k - 1],
                     k == n - 1, !ok && (k == n - 1), CODE_BUS);
          end
          seq_phase = ok ? PH_VALUE : PH_IDLE;
        end
        PH_VALUE: begin
          if (!ok) begin
            abort_measurement(CMD_READ_VALUE, CODE_BUS);
          end else begin
            timed_out = retries > {1'b0, sample_limit};
            if (retries != RETRY_MAX) begin
              retries = retries + 17'd1;
            end
            code = flag_priority(errw);
            if (timed_out) begin
              abort_measurement(CMD_READ_VALUE, CODE_NOT_READY);
            end else if (code == CODE_NOT_READY) begin
              emit_cmd(CMD_READ_VALUE, DELAY_VALUE, 8'd0, 1'b1, 1'b0, CODE_OK);
            end else if (code != CODE_OK) begin
              abort_measurement(CMD_READ_VALUE, code);
            end else begin
              co2_hold   = co2w;
              temp_hold  = tempw;
              known_hold = 1'b1;
              if (single_mode) begin
                seq_phase = PH_STATUS;
                emit_cmd(CMD_READ_VALUE, DELAY_SHORT, 8'd0, 1'b1, 1'b1, CODE_OK);
              end else begin
                seq_phase = PH_IDLE;
                emit_cmd(CMD_READ_VALUE, DELAY_END, 8'd0, 1'b1, 1'b1, CODE_OK);
              end
            end
          end
        end
        PH_STATUS: begin
          for (k = 0; k < STATUS_BYTES; k++) begin
            saved_bytes[k] = 8'd0;
          end
          if (!ok) begin
            seq_phase = PH_IDLE;
            emit_cmd(CMD_READ_STATUS, DELAY_END, 8'd0, 1'b1, 1'b1, CODE_BUS);
          end else begin
            status_fill = 0;
            seq_phase   = PH_COLLECT;
            emit_cmd(CMD_READ_STATUS, DELAY_NONE, 8'd0, 1'b1, 1'b0, CODE_OK);
          end
        end
        default: begin
        end
      endcase
    end
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    int      k;
    if (!rst_n) begin
      single_mode  = 1'b0;
      sample_limit = 16'd1;
      seq_phase    = PH_IDLE;
      retries      = '0;
      status_fill  = 0;
      for (k = 0; k < STATUS_BYTES; k++) begin
        saved_bytes[k] = 8'd0;
      end
      mark_unknown();
      awaited_cmds.delete();
      fail_count = 0;
      checked    = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.command = out_tdata[2:0];
        got.delay   = out_tdata[11:3];
        got.payload = out_tdata[19:12];
        got.co2     = out_tdata[35:20];
        got.temp    = out_tdata[51:36];
        got.known   = out_tdata[52];
        got.code    = out_tdata[56:53];
        got.update  = out_tdata[57];
        got.last    = out_tlast;
        if (awaited_cmds.size() == 0) begin
          $error("Result transaction with nothing expected: command %0d", got.command);
          fail_count++;
        end else begin
          want = awaited_cmds.pop_front();
          check_field("command", want.command, got.command);
          check_field("delay_ms", want.delay, got.delay);
          check_field("payload_byte", want.payload, got.payload);
          check_field("last", want.last, got.last);
          check_field("co2_value", want.co2, got.co2);
          check_field("temp_centi", want.temp, got.temp);
          check_field("temp_known", want.known, got.known);
          check_field("status_code", want.code, got.code);
          check_field("status_update", want.update, got.update);
          checked++;
        end
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == ADDR_SINGLE_MODE) begin
          single_mode = pwdata[0];
        end else begin
          sample_limit = pwdata[15:0];
        end
      end
      if (in_tvalid && in_tready) begin
        advance_sequence(in_tuser, in_tdata[0], in_tdata[8:1], in_tdata[24:9],
                         in_tdata[40:25], in_tdata[56:41], in_tdata[64:57], in_tlast);
      end
    end
    pending = awaited_cmds.size();
  end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// Testbench top for the CO2 measurement sequencer: stimulus, handshake pacing and verdict.
module tb;
  import co2msq_pkg::*;

  localparam int STATUS_BYTES = 24;
  localparam int ITEM_TARGET  = 210;
  localparam int LONG_STALL   = 300;
  localparam int SETTLE       = 8;

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata;
  logic [1:0] in_tuser;
  logic in_tlast;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic out_tlast;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  int fail_count;
  int pending;
  int checked;
  int items_sent = 0;
  int settings_done = 0;
  bit calm = 1'b0;
  bit stall_request = 1'b0;
  logic single_cfg = 1'b0;

  always #5 clk = ~clk;

  co2_sensor_measure_sequencer_top #(
    .STATUS_BYTES(STATUS_BYTES)
  ) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  co2msq_tb_checker #(
    .STATUS_BYTES(STATUS_BYTES)
  ) i_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .fail_count(fail_count), .pending(pending), .checked(checked)
  );

  task automatic offer_request(logic [1:0] req, logic ok, logic [7:0] mode, logic [15:0] errw,
                               logic [15:0] co2w, logic [15:0] tempw, logic [7:0] sbyte,
                               logic send);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tlast  <= send;
    in_tdata  <= {7'd0, sbyte, tempw, co2w, errw, mode, ok};
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  task automatic write_register(logic idx, logic [31:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    if (idx == ADDR_SINGLE_MODE) begin
      single_cfg = value[0];
    end
  endtask

  task automatic settle_block();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic wake_ok();
    return $urandom_range(0, 15) != 0;
  endfunction

  task automatic stray_request();
    if ($urandom_range(0, 7) == 0) begin
      offer_request(2'($urandom), 1'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom), 8'($urandom), 1'($urandom));
    end
  endtask

  task automatic run_measurement();
    int tries;
    int nbytes;
    int k;
    logic [15:0] errw;
    logic [7:0] mode;
    stray_request();
    offer_request(REQ_START, 1'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 8'($urandom), 1'($urandom));
    mode = ($urandom_range(0, 9) == 0) ? 8'($urandom) : {7'd0, single_cfg};
    offer_request(REQ_WAKE, wake_ok(), mode, 16'($urandom), 16'($urandom), 16'($urandom),
                  8'($urandom), 1'($urandom));
    if (single_cfg) begin
      offer_request(REQ_WAKE, wake_ok(), 8'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom), 8'($urandom), 1'($urandom));
    end
    tries = $urandom_range(0, 3);
    for (k = 0; k < tries; k++) begin
      offer_request(REQ_WAKE, wake_ok(), 8'($urandom), 16'h0080 | (16'($urandom) & 16'hFF00),
                    16'($urandom), 16'($urandom), 8'($urandom), 1'($urandom));
    end
    case ($urandom_range(0, 9))
      6: errw = 16'd1 << $urandom_range(0, 15);
      7: errw = 16'($urandom);
      default: errw = 16'd0;
    endcase
    offer_request(REQ_WAKE, wake_ok(), 8'($urandom), errw, 16'($urandom), 16'($urandom),
                  8'($urandom), 1'($urandom));
    if (single_cfg) begin
      offer_request(REQ_WAKE, wake_ok(), 8'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom), 8'($urandom), 1'($urandom));
      stray_request();
      nbytes = $urandom_range(1, STATUS_BYTES + 4);
      for (k = 0; k < nbytes; k++) begin
        offer_request(REQ_STATUS, 1'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom),
                      k == nbytes - 1);
      end
    end
    offer_request(REQ_WAKE, 1'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 8'($urandom), 1'($urandom));
  endtask

  initial begin : receiver
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_request) begin
        stall_request = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
        out_tready <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    #(5_000_000);
    $display("tb: FAIL");
    $finish;
  end

  initial begin : stimulus
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= REQ_START;
    in_tlast  <= 1'b0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part in continuous mode with no retries allowed.
    write_register(ADDR_SINGLE_MODE, 32'd0);
    write_register(ADDR_SAMPLE_LIMIT, 32'd0);
    offer_request(REQ_WAKE, 1'b1, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b0);
    offer_request(2'd3, 1'b1, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1);
    offer_request(REQ_STATUS, 1'b0, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'hFF, 1'b1);
    offer_request(REQ_START, 1'b0, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b0);
    offer_request(REQ_START, 1'b1, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1);
    offer_request(REQ_WAKE, 1'b0, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b0);
    offer_request(REQ_START, 1'b1, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b0);
    offer_request(REQ_WAKE, 1'b1, 8'h01, 16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b0);
    offer_request(REQ_START, 1'b1, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b0);
    offer_request(REQ_WAKE, 1'b1, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b0);
    offer_request(REQ_WAKE, 1'b1, 8'h00, 16'h0080, 16'h1234, 16'h0987, 8'h00, 1'b0);
    offer_request(REQ_WAKE, 1'b1, 8'h00, 16'h0000, 16'h1234, 16'h0987, 8'h00, 1'b0);
    offer_request(REQ_START, 1'b1, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b0);
    offer_request(REQ_WAKE, 1'b1, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b0);
    offer_request(REQ_WAKE, 1'b1, 8'h00, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h00, 1'b0);
    offer_request(REQ_START, 1'b1, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b0);
    offer_request(REQ_WAKE, 1'b1, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b0);
    offer_request(REQ_WAKE, 1'b1, 8'h00, 16'hF800, 16'h0000, 16'h0000, 8'h00, 1'b0);
    offer_request(REQ_START, 1'b1, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b0);
    offer_request(REQ_WAKE, 1'b1, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b0);
    offer_request(REQ_WAKE, 1'b0, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b0);
    offer_request(REQ_START, 1'b1, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b0);
    offer_request(REQ_WAKE, 1'b1, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b0);
    offer_request(REQ_WAKE, 1'b1, 8'h00, 16'h0000, 16'hFFFF, 16'hFFFF, 8'h00, 1'b0);
    offer_request(REQ_WAKE, 1'b1, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b0);

    // Random part: whole measurements under changing register settings.
    while (items_sent < ITEM_TARGET) begin
      settle_block();
      if (items_sent >= ITEM_TARGET - 35) begin
        calm = 1'b1;
      end
      case (settings_done % 4)
        0: begin
          write_register(ADDR_SINGLE_MODE, 32'd1);
          write_register(ADDR_SAMPLE_LIMIT, $urandom_range(0, 3));
        end
        1: begin
          write_register(ADDR_SINGLE_MODE, 32'd0);
          write_register(ADDR_SAMPLE_LIMIT, 32'd0);
        end
        2: begin
          write_register(ADDR_SINGLE_MODE, 32'd1);
          write_register(ADDR_SAMPLE_LIMIT, 32'h0000_FFFF);
        end
        default: begin
          write_register(ADDR_SINGLE_MODE, $urandom);
          write_register(ADDR_SAMPLE_LIMIT, $urandom);
        end
      endcase
      if (settings_done == 2) begin
        stall_request = 1'b1;
      end
      settings_done++;
      run_measurement();
      run_measurement();
    end

    calm = 1'b1;
    settle_block();
    $display("Run covered %0d requests over %0d register settings; %0d results checked.",
             items_sent, settings_done, checked);
    if (fail_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/co2msq_pkg.sv
hw/rtl/co2msq_ctrl.sv
hw/rtl/co2msq_dp.sv
hw/rtl/co2_sensor_measure_sequencer_top.sv
hw/rtl/co2msq_checker.sv
dv/co2msq_checker.sv
dv/tb.sv
